### rtl/core/ddnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddnc_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam int VAL_W = 23;
  localparam logic [3:0] STEP_LAST  = 4'd14;
  localparam logic [3:0] STEP_QUOT  = 4'd6;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_SUM,
    ST_MOD,
    ST_OUT
  } ddnc_state_t;

  typedef struct packed {
    logic        operation;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [13:0] year_in;
    logic [21:0] day_number;
  } ddnc_item_t;

  typedef struct packed {
    logic [21:0] serial_day;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  mday_out;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
    logic [2:0]  first_weekday;
    logic        range_error;
  } ddnc_result_t;

  function automatic logic [VAL_W-1:0] step_days(input logic [3:0] idx);
    logic [VAL_W-1:0] v;
    case (idx)
      4'd0:    v = 23'd4675104;
      4'd1:    v = 23'd2337552;
      4'd2:    v = 23'd1168776;
      4'd3:    v = 23'd584388;
      4'd4:    v = 23'd292194;
      4'd5:    v = 23'd146097;
      4'd6:    v = 23'd73048;
      4'd7:    v = 23'd36524;
      4'd8:    v = 23'd23376;
      4'd9:    v = 23'd11688;
      4'd10:   v = 23'd5844;
      4'd11:   v = 23'd2922;
      4'd12:   v = 23'd1461;
      4'd13:   v = 23'd730;
      4'd14:   v = 23'd365;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] step_years(input logic [3:0] idx);
    logic [VAL_W-1:0] v;
    case (idx)
      4'd0:    v = 23'd12800;
      4'd1:    v = 23'd6400;
      4'd2:    v = 23'd3200;
      4'd3:    v = 23'd1600;
      4'd4:    v = 23'd800;
      4'd5:    v = 23'd400;
      4'd6:    v = 23'd200;
      4'd7:    v = 23'd100;
      4'd8:    v = 23'd64;
      4'd9:    v = 23'd32;
      4'd10:   v = 23'd16;
      4'd11:   v = 23'd8;
      4'd12:   v = 23'd4;
      4'd13:   v = 23'd2;
      4'd14:   v = 23'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    case (m)
      4'd0:    v = 5'd31;
      4'd1:    v = leap ? 5'd29 : 5'd28;
      4'd2:    v = 5'd31;
      4'd3:    v = 5'd30;
      4'd4:    v = 5'd31;
      4'd5:    v = 5'd30;
      4'd6:    v = 5'd31;
      4'd7:    v = 5'd31;
      4'd8:    v = 5'd30;
      4'd9:    v = 5'd31;
      4'd10:   v = 5'd30;
      4'd11:   v = 5'd31;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // 8 == 1 mod 7: fold octal digits
  function automatic logic [2:0] mod7(input logic [VAL_W-1:0] x);
    logic [VAL_W:0] xe;
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    xe = {1'b0, x};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + {3'b000, xe[3*i +: 3]};
    end
    s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
    s3 = {3'b000, s2[3]} + {1'b0, s2[2:0]};
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/ddnc_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module ddnc_step_unit (
  input  wire logic [ddnc_pkg::VAL_W-1:0] rem_in,
  input  wire logic [ddnc_pkg::VAL_W-1:0] div_in,
  input  wire logic [ddnc_pkg::VAL_W-1:0] acc_in,
  input  wire logic [ddnc_pkg::VAL_W-1:0] wt_in,
  output logic                            ge,
  output logic [ddnc_pkg::VAL_W-1:0]      rem_out,
  output logic [ddnc_pkg::VAL_W-1:0]      acc_out
);
  import ddnc_pkg::*;

  logic [VAL_W:0] diff;

  assign diff    = {1'b0, rem_in} - {1'b0, div_in};
  assign ge      = ~diff[VAL_W];
  assign rem_out = ge ? diff[VAL_W-1:0] : rem_in;
  assign acc_out = ge ? (acc_in + wt_in) : acc_in;

endmodule

`default_nettype wire

### rtl/core/ddnc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ddnc_core #(
  parameter int unsigned MAX_YEAR = ddnc_pkg::MAX_YEAR_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire ddnc_pkg::ddnc_item_t  item,
  input  wire logic                  take,
  output logic                       ready,
  output logic                       res_valid,
  output ddnc_pkg::ddnc_result_t     res
);
  import ddnc_pkg::*;

  localparam int unsigned MaxSerial =
    MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  ddnc_state_t state_r, state_nxt;

  logic               op_r, op_nxt;
  logic [3:0]         mon_r, mon_nxt;
  logic [4:0]         mday_r, mday_nxt;
  logic [13:0]        year_r, year_nxt;
  logic [21:0]        dnum_r, dnum_nxt;
  logic [VAL_W-1:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic [VAL_W-1:0]   base_r, base_nxt;
  logic [VAL_W-1:0]   serial_r, serial_nxt;
  logic [VAL_W-1:0]   fbase_r, fbase_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic [3:0]         m_r, m_nxt;
  logic [8:0]         q_r, q_nxt;
  logic [8:0]         yday_r, yday_nxt;
  ddnc_result_t       res_r, res_nxt;

  logic [VAL_W-1:0]   st_div, st_wt, st_rem, st_acc;
  logic               st_ge;
  logic               leap;
  logic [4:0]         mlen;
  logic [8:0]         sum_bm;
  logic [VAL_W-1:0]   base_p1;
  logic               err_in;

  function automatic logic [3:0] m0_r_sel(input logic [3:0] mon);
    logic [3:0] v;
    if (mon == 4'd0) begin
      v = 4'd0;
    end else if (mon > 4'd12) begin
      v = 4'd12;
    end else begin
      v = mon - 4'd1;
    end
    return v;
  endfunction

  // q_r holds {q100, q4, q1} of the year decomposition
  assign leap = (q_r[1:0] == 2'd3) && !((q_r[6:2] == 5'd24) && (q_r[8:7] != 2'd3));
  assign mlen = month_len(m_r, leap);

  assign sum_bm  = acc_r[8:0] + {4'b0000, mday_r};
  assign base_p1 = base_r + 23'd1;

  assign err_in = item.operation ?
    ((item.day_number == 22'd0) || ({3'b000, item.day_number} > 25'(MaxSerial))) :
    ((item.year_in == 14'd0) || ({3'b000, item.year_in} > 17'(MAX_YEAR)));

  always_comb begin
    st_div = '0;
    st_wt  = '0;
    case (state_r)
      ST_YEAR: begin
        st_div = op_r ? step_days(idx_r) : step_years(idx_r);
        st_wt  = op_r ? step_years(idx_r) : step_days(idx_r);
      end
      ST_MONTH: begin
        st_div = op_r ? {18'd0, mlen} : 23'd1;
        st_wt  = op_r ? '0 : {18'd0, mlen};
      end
      default: begin
        st_div = '0;
        st_wt  = '0;
      end
    endcase
  end

  ddnc_step_unit u_step (
    .rem_in  (rem_r),
    .div_in  (st_div),
    .acc_in  (acc_r),
    .wt_in   (st_wt),
    .ge      (st_ge),
    .rem_out (st_rem),
    .acc_out (st_acc)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    mon_nxt    = mon_r;
    mday_nxt   = mday_r;
    year_nxt   = year_r;
    dnum_nxt   = dnum_r;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    serial_nxt = serial_r;
    fbase_nxt  = fbase_r;
    idx_nxt    = idx_r;
    m_nxt      = m_r;
    q_nxt      = q_r;
    yday_nxt   = yday_r;
    res_nxt    = res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = item.operation;
          mon_nxt  = item.month;
          mday_nxt = item.day_of_month;
          year_nxt = item.year_in;
          dnum_nxt = item.day_number;
          acc_nxt  = '0;
          idx_nxt  = '0;
          q_nxt    = '0;
          rem_nxt  = item.operation ? {1'b0, item.day_number - 22'd1}
                                    : {9'd0, item.year_in - 14'd1};
          if (err_in) begin
            res_nxt             = '0;
            res_nxt.range_error = 1'b1;
            state_nxt           = ST_OUT;
          end else begin
            state_nxt = ST_YEAR;
          end
        end
      end
      ST_YEAR: begin
        rem_nxt = st_rem;
        acc_nxt = st_acc;
        if (idx_r >= STEP_QUOT) begin
          q_nxt = {q_r[7:0], st_ge};
        end
        if (idx_r == STEP_LAST) begin
          base_nxt = st_acc;
          m_nxt    = '0;
          yday_nxt = st_rem[8:0];
          if (!op_r) begin
            rem_nxt = {19'd0, m0_r_sel(mon_r)};
            acc_nxt = '0;
          end
          state_nxt = ST_MONTH;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      ST_MONTH: begin
        if (op_r) begin
          if ((m_r == MONTH_LAST) || !st_ge) begin
            state_nxt = ST_SUM;
          end else begin
            rem_nxt = st_rem;
            m_nxt   = m_r + 4'd1;
          end
        end else begin
          if (!st_ge) begin
            state_nxt = ST_SUM;
          end else begin
            rem_nxt = st_rem;
            acc_nxt = st_acc;
            m_nxt   = m_r + 4'd1;
          end
        end
      end
      ST_SUM: begin
        res_nxt.range_error = 1'b0;
        if (op_r) begin
          serial_nxt          = {1'b0, dnum_r};
          fbase_nxt           = {1'b0, dnum_r} - rem_r;
          res_nxt.serial_day  = dnum_r;
          res_nxt.year_out    = base_p1[13:0];
          res_nxt.month_out   = m_r + 4'd1;
          res_nxt.mday_out    = rem_r[4:0] + 5'd1;
          res_nxt.day_of_year = yday_r;
        end else begin
          serial_nxt          = base_r + {14'd0, sum_bm};
          fbase_nxt           = base_r + acc_r + 23'd1;
          res_nxt.serial_day  = serial_nxt[21:0];
          res_nxt.year_out    = year_r;
          res_nxt.month_out   = mon_r;
          res_nxt.mday_out    = mday_r;
          res_nxt.day_of_year = (sum_bm == 9'd0) ? 9'd0 : (sum_bm - 9'd1);
        end
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        res_nxt.weekday       = mod7(serial_r);
        res_nxt.first_weekday = mod7(fbase_r);
        state_nxt             = ST_OUT;
      end
      ST_OUT: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    mon_r    <= mon_nxt;
    mday_r   <= mday_nxt;
    year_r   <= year_nxt;
    dnum_r   <= dnum_nxt;
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    base_r   <= base_nxt;
    serial_r <= serial_nxt;
    fbase_r  <= fbase_nxt;
    idx_r    <= idx_nxt;
    m_r      <= m_nxt;
    q_r      <= q_nxt;
    yday_r   <= yday_nxt;
    res_r    <= res_nxt;
  end

  assign ready     = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_OUT);
  assign res       = res_r;

  a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH && op_r) |-> (m_r <= MONTH_LAST && rem_r < 23'd366))
    else $error("month walk out of bounds");

  a_year_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR && $past(state_r) != ST_YEAR) |-> $past(state_r) == ST_IDLE)
    else $error("year phase entered from wrong state");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && res_r.range_error) |->
      (res_r.serial_day == 22'd0 && res_r.year_out == 14'd0 && res_r.weekday == 3'd0))
    else $error("range error result carries data");

  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (res_r.weekday < 3'd7 && res_r.first_weekday < 3'd7))
    else $error("weekday out of range");

  a_take_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !take) |=> (state_r == ST_OUT && $stable(res_r)))
    else $error("result lost before taken");

endmodule

`default_nettype wire

### rtl/core/date_day_number_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake         | Payload
// in      | input     | in_tvalid/tready  | in_tdata (date or day number), in_tuser (operation)
// out     | output    | out_tvalid/tready | out_tdata (converted date), out_tuser (range_error)
//
// An out-of-range input goes from idle straight to the result hand-off. Otherwise an item takes
// 15 steps of the shared compare-subtract unit for the year decomposition, 1 to 13 for the
// month walk, then sum, weekday, hand-off and a return to idle.
// One item is in work at a time.
// Synchronous active-low reset returns the sequencer to idle and empties the output stage.
// A stalled output holds its item; the next item is accepted once the result moves there.

module date_day_number_converter_unit #(
  parameter int unsigned MAX_YEAR = ddnc_pkg::MAX_YEAR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // month[3:0], day_of_month[8:4], year_in[22:9],
                                      // day_number[44:23], zero[47:45]
  input  wire logic        in_tuser,  // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // serial_day[21:0], year_out[35:22], month_out[39:36],
                                      // mday_out[44:40], day_of_year[53:45],
                                      // weekday[56:54], first_weekday[59:57], zero[63:60]
  output logic             out_tuser  // range_error
);
  import ddnc_pkg::*;

  ddnc_item_t   item;
  ddnc_result_t core_res;
  ddnc_result_t out_r;
  logic         out_valid_r, out_valid_nxt;
  logic         core_ready;
  logic         core_valid;
  logic         take;
  logic         start;

  assign item.operation    = in_tuser;
  assign item.month        = in_tdata[3:0];
  assign item.day_of_month = in_tdata[8:4];
  assign item.year_in      = in_tdata[22:9];
  assign item.day_number   = in_tdata[44:23];

  assign in_tready = core_ready;
  assign start     = in_tvalid && core_ready;
  assign take      = core_valid && (!out_valid_r || out_tready);

  ddnc_core #(
    .MAX_YEAR (MAX_YEAR)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .take      (take),
    .ready     (core_ready),
    .res_valid (core_valid),
    .res       (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.first_weekday, out_r.weekday, out_r.day_of_year,
                       out_r.mday_out, out_r.month_out, out_r.year_out, out_r.serial_day};
  assign out_tuser  = out_r.range_error;

endmodule

`default_nettype wire

### tb/date_conversion_checker.sv
`timescale 1ns / 1ps

package date_conv_tb_pkg;

  typedef enum logic {
    OP_DATE_TO_SERIAL = 1'b0,
    OP_SERIAL_TO_DATE = 1'b1
  } conv_op_t;

endpackage

module date_conversion_checker #(
  parameter int unsigned MAX_YEAR = ddnc_pkg::MAX_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          to_serial_count,
  output int          to_date_count,
  output int          range_error_count
);
  import ddnc_pkg::*;
  import date_conv_tb_pkg::*;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam longint unsigned DAYS_400Y = 146097;
  localparam longint unsigned DAYS_100Y = 36524;
  localparam longint unsigned DAYS_4Y   = 1461;
  localparam longint unsigned DAYS_1Y   = 365;

  ddnc_result_t expected_dates[$];
  int fails = 0;
  int outstanding = 0;
  int n_to_serial = 0;
  int n_to_date = 0;
  int n_range_err = 0;

  assign fail_count        = fails;
  assign pending           = outstanding;
  assign to_serial_count   = n_to_serial;
  assign to_date_count     = n_to_date;
  assign range_error_count = n_range_err;

  function automatic bit leap_year(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned days_before_year(input longint unsigned y);
    longint unsigned d;
    d = y - 1;
    return d * 365 + d / 4 - d / 100 + d / 400;
  endfunction

  function automatic ddnc_result_t convert_date(input ddnc_item_t it);
    ddnc_result_t res;
    longint unsigned yr, mon, md, dnum, serial, yday, acc, lim, n, r;
    longint unsigned q400, q100, q4, q1, m, len;
    bit err;
    int i;
    res = '0;
    err = 1'b0;
    yr = it.year_in;
    mon = it.month;
    md = it.day_of_month;
    dnum = it.day_number;
    serial = 0;
    yday = 0;
    if (it.operation == OP_DATE_TO_SERIAL) begin
      if (yr == 0 || yr > MAX_YEAR) begin
        err = 1'b1;
      end else begin
        lim = (mon == 0) ? 0 : mon - 1;
        if (lim > 12) begin
          lim = 12;
        end
        acc = 0;
        for (i = 0; i < 12; i++) begin
          if (i < lim) begin
            acc += MONTH_DAYS[i];
            if (i == 1 && leap_year(yr)) begin
              acc += 1;
            end
          end
        end
        serial = days_before_year(yr) + acc + md;
        yday = (acc + md == 0) ? 0 : acc + md - 1;
      end
    end else begin
      if (dnum == 0 || dnum > days_before_year(longint'(MAX_YEAR) + 1)) begin
        err = 1'b1;
      end else begin
        n = dnum - 1;
        q400 = n / DAYS_400Y;
        r = n % DAYS_400Y;
        q100 = r / DAYS_100Y;
        if (q100 > 3) begin
          q100 = 3;
        end
        r -= q100 * DAYS_100Y;
        q4 = r / DAYS_4Y;
        r -= q4 * DAYS_4Y;
        q1 = r / DAYS_1Y;
        if (q1 > 3) begin
          q1 = 3;
        end
        r -= q1 * DAYS_1Y;
        yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        yday = r;
        serial = dnum;
        m = 0;
        len = MONTH_DAYS[0];
        while (m < 11 && r >= len) begin
          r -= len;
          m++;
          len = MONTH_DAYS[m] + ((m == 1 && leap_year(yr)) ? 1 : 0);
        end
        mon = m + 1;
        md = r + 1;
      end
    end
    if (err) begin
      res.range_error = 1'b1;
    end else begin
      res.serial_day    = 22'(serial);
      res.year_out      = 14'(yr);
      res.month_out     = 4'(mon);
      res.mday_out      = 5'(md);
      res.day_of_year   = 9'(yday);
      res.weekday       = 3'(serial % 7);
      res.first_weekday = 3'((serial - md + 1) % 7);
      res.range_error   = 1'b0;
    end
    return res;
  endfunction

  function automatic string show_date(input ddnc_result_t d);
    return $sformatf("serial=%0d year=%0d month=%0d mday=%0d yday=%0d wday=%0d first=%0d err=%0b",
                     d.serial_day, d.year_out, d.month_out, d.mday_out, d.day_of_year,
                     d.weekday, d.first_weekday, d.range_error);
  endfunction

  always @(posedge clk) begin : watch
    ddnc_item_t   it;
    ddnc_result_t got;
    ddnc_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.operation    = in_tuser;
        it.month        = in_tdata[3:0];
        it.day_of_month = in_tdata[8:4];
        it.year_in      = in_tdata[22:9];
        it.day_number   = in_tdata[44:23];
        want = convert_date(it);
        expected_dates.push_back(want);
        if (it.operation == OP_DATE_TO_SERIAL) begin
          n_to_serial++;
        end else begin
          n_to_date++;
        end
        if (want.range_error) begin
          n_range_err++;
        end
      end
      if (out_tvalid && out_tready) begin
        got.serial_day    = out_tdata[21:0];
        got.year_out      = out_tdata[35:22];
        got.month_out     = out_tdata[39:36];
        got.mday_out      = out_tdata[44:40];
        got.day_of_year   = out_tdata[53:45];
        got.weekday       = out_tdata[56:54];
        got.first_weekday = out_tdata[59:57];
        got.range_error   = out_tuser;
        if (expected_dates.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected result %s", $time, show_date(got));
          end
          fails++;
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            if (fails < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", show_date(want));
              $display("  actual   %s", show_date(got));
            end
            fails++;
          end
        end
      end
      outstanding = expected_dates.size();
    end
  end

endmodule

### tb/date_day_number_converter_unit_test.sv
`timescale 1ns / 1ps

module date_day_number_converter_unit_test;
  import ddnc_pkg::*;
  import date_conv_tb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  int fail_count;
  int pending;
  int to_serial_count;
  int to_date_count;
  int range_error_count;
  int cycle_count = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  date_day_number_converter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  date_conversion_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .fail_count        (fail_count),
    .pending           (pending),
    .to_serial_count   (to_serial_count),
    .to_date_count     (to_date_count),
    .range_error_count (range_error_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  initial begin : ready_gen
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (out_stalls_on) begin
          stall = pick_gap();
        end
      end
    end
  end

  // fill the fields that the chosen operation ignores with noise
  function automatic ddnc_item_t make_item(input conv_op_t op, input int mon, input int md,
                                           input int yr, input int dnum);
    ddnc_item_t it;
    it.operation = op;
    if (op == OP_DATE_TO_SERIAL) begin
      it.month        = 4'(mon);
      it.day_of_month = 5'(md);
      it.year_in      = 14'(yr);
      it.day_number   = 22'($urandom);
    end else begin
      it.month        = 4'($urandom);
      it.day_of_month = 5'($urandom);
      it.year_in      = 14'($urandom);
      it.day_number   = 22'(dnum);
    end
    return it;
  endfunction

  task automatic send_item(input ddnc_item_t it);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it.day_number, it.year_in, it.day_of_month, it.month};
    in_tuser  <= it.operation;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic ddnc_item_t random_item();
    int r;
    int y;
    longint d;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      y = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 9999);
      return make_item(OP_DATE_TO_SERIAL, $urandom_range(1, 12),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28),
                       y, 0);
    end else if (r < 60) begin
      return make_item(OP_SERIAL_TO_DATE, 0, 0, 0, $urandom_range(1, 3652059));
    end else if (r < 75) begin
      // land around a new year
      y = $urandom_range(1, 10000);
      d = longint'(y - 1) * 365 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
          + $urandom_range(0, 2) - 1;
      return make_item(OP_SERIAL_TO_DATE, 0, 0, 0, int'(d));
    end
    return make_item(conv_op_t'($urandom_range(0, 1)), $urandom_range(0, 15),
                     $urandom_range(0, 31), $urandom_range(0, 16383),
                     $urandom_range(0, 4194303));
  endfunction

  initial begin : stimulus
    ddnc_item_t directed_items[$];
    int p;
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 1, 1, 1, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 12, 31, 9999, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 2, 29, 2000, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 2, 29, 1900, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 3, 1, 2024, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 12, 31, 400, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 0, 15, 2023, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 13, 1, 2023, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 15, 31, 9999, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 1, 0, 1, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 0, 0, 1, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 3, 0, 2000, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 2, 31, 2021, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 1, 1, 0, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 6, 15, 10000, 0));
    directed_items.push_back(make_item(OP_DATE_TO_SERIAL, 15, 31, 16383, 0));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 1));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 3652059));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 3652060));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 0));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 4194303));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 146097));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 146098));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 36524));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 1461));
    directed_items.push_back(make_item(OP_SERIAL_TO_DATE, 0, 0, 0, 730179));
    foreach (directed_items[i]) begin
      send_item(directed_items[i]);
    end

    for (p = 0; p < PHASES; p++) begin
      in_gaps_on    = (p == 0) || (p == 2);
      out_stalls_on = (p == 0) || (p == 1);
      for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        send_item(random_item());
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d date-to-serial and %0d serial-to-date conversions, %0d out of range",
             to_serial_count, to_date_count, range_error_count);
    $display("input gaps and output stalls varied over %0d phases, %0d mismatches",
             PHASES, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
